>>> hdl/cmaf_pkg.sv
// Shared types for the centered moving average frame smoother.
package cmaf_pkg;

    typedef struct packed {
        logic frame_end;
        logic run_last;
    } t_res_flags;

    localparam int FLAGS_W = $bits(t_res_flags);

endpackage

>>> hdl/cmaf_queue.sv
// Small register queue that carries averaging jobs from the front to the back.
module cmaf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> hdl/cmaf_front.sv
// Front part: keeps the bin window, running sum and position, and issues averaging jobs.
module cmaf_front import cmaf_pkg::*; #(
    parameter int HALF_WIDTH  = 5,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic [SAMPLE_BITS-1:0]  i_bin_value,
    input  logic                    i_frame_last,
    output logic                    o_job_push,
    input  logic                    i_job_full,
    output logic signed [SAMPLE_BITS+$clog2(2*HALF_WIDTH+1)-1:0] o_job_sum,
    output logic [$clog2(2*HALF_WIDTH+2)-1:0] o_job_cnt,
    output t_res_flags              o_job_flags
);

    localparam int WIN_LEN = 2 * HALF_WIDTH + 1;
    localparam int CNT_W   = $clog2(WIN_LEN + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WIN_LEN);
    localparam int IDX_W   = $clog2(WIN_LEN);
    localparam int LEFT_W  = $clog2(HALF_WIDTH + 1);

    logic signed [SAMPLE_BITS-1:0] r_win [WIN_LEN];
    logic signed [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]              r_pos;
    logic                          r_flush;
    logic [LEFT_W-1:0]             r_left;

    logic                          accept;
    logic                          step;
    logic [CNT_W-1:0]              pos_n;
    logic signed [SAMPLE_BITS-1:0] x_in;
    logic signed [SAMPLE_BITS-1:0] drop;
    logic signed [SUM_W-1:0]       sum_n;
    logic [LEFT_W-1:0]             top;
    logic                          need_drop;
    logic [IDX_W-1:0]              f_idx;
    logic signed [SUM_W-1:0]       f_sum;
    logic [CNT_W-1:0]              f_k;
    logic                          last_step;

    assign o_full = r_flush || i_job_full;
    assign accept = i_push && !o_full;
    assign step   = r_flush && !i_job_full;
    assign x_in   = signed'(i_bin_value);

    always_comb begin
        pos_n = (r_pos < CNT_W'(WIN_LEN)) ? r_pos + 1'b1 : r_pos;
        drop  = (r_pos == CNT_W'(WIN_LEN)) ? r_win[WIN_LEN-1] : '0;
        sum_n = r_sum - SUM_W'(drop) + SUM_W'(x_in);
        top   = (pos_n < CNT_W'(HALF_WIDTH)) ? LEFT_W'(pos_n) : LEFT_W'(HALF_WIDTH);
    end

    always_comb begin
        need_drop = ((CNT_W+1)'(r_left) + (CNT_W+1)'(HALF_WIDTH)) < (CNT_W+1)'(r_pos);
        f_idx     = IDX_W'(r_pos - 1'b1);
        f_sum     = need_drop ? r_sum - SUM_W'(r_win[f_idx]) : r_sum;
        f_k       = need_drop ? r_pos - 1'b1 : r_pos;
        last_step = (r_left == LEFT_W'(1));
    end

    always_comb begin
        o_job_push  = 1'b0;
        o_job_sum   = sum_n;
        o_job_cnt   = pos_n;
        o_job_flags = '{frame_end: 1'b0, run_last: !i_frame_last};
        if (accept) begin
            o_job_push = (pos_n > CNT_W'(HALF_WIDTH));
        end else if (step) begin
            o_job_push  = 1'b1;
            o_job_sum   = f_sum;
            o_job_cnt   = f_k;
            o_job_flags = '{frame_end: last_step, run_last: last_step};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_pos   <= '0;
            r_flush <= 1'b0;
            r_left  <= '0;
        end else if (accept) begin
            r_sum <= sum_n;
            r_pos <= pos_n;
            if (i_frame_last) begin
                r_flush <= 1'b1;
                r_left  <= top;
            end
        end else if (step) begin
            r_left <= r_left - 1'b1;
            if (last_step) begin
                r_flush <= 1'b0;
                r_sum   <= '0;
                r_pos   <= '0;
            end else begin
                r_sum <= f_sum;
                r_pos <= f_k;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win[0] <= x_in;
            for (int j = 1; j < WIN_LEN; j++) begin
                r_win[j] <= r_win[j-1];
            end
        end
    end

endmodule

>>> hdl/cmaf_back.sv
// Back part: divides each job's sum by its bin count and holds the result beat.
module cmaf_back import cmaf_pkg::*; #(
    parameter int HALF_WIDTH  = 5,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_job_empty,
    output logic                    o_job_pop,
    input  logic signed [SAMPLE_BITS+$clog2(2*HALF_WIDTH+1)-1:0] i_job_sum,
    input  logic [$clog2(2*HALF_WIDTH+2)-1:0] i_job_cnt,
    input  t_res_flags              i_job_flags,
    output logic                    o_empty,
    input  logic                    i_pop,
    output logic [SAMPLE_BITS-1:0]  o_value,
    output t_res_flags              o_flags
);

    localparam int WIN_LEN = 2 * HALF_WIDTH + 1;
    localparam int CNT_W   = $clog2(WIN_LEN + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WIN_LEN);
    localparam int STEP_W  = $clog2(SUM_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]              r_state;
    logic [STEP_W-1:0]       r_step;
    logic [SUM_W-1:0]        r_quo;
    logic [CNT_W-1:0]        r_rem;
    logic [CNT_W-1:0]        r_div;
    logic                    r_neg;
    t_res_flags              r_flg;
    logic                    r_ovalid;
    logic [SAMPLE_BITS-1:0]  r_oval;
    t_res_flags              r_oflg;

    logic [CNT_W:0]          trial;
    logic                    fits;
    logic [SUM_W-1:0]        res;
    logic                    out_free;

    assign o_job_pop = (r_state == ST_IDLE) && !i_job_empty;
    assign out_free  = !r_ovalid || i_pop;
    assign o_empty   = !r_ovalid;
    assign o_value   = r_oval;
    assign o_flags   = r_oflg;

    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        fits  = trial >= {1'b0, r_div};
        res   = r_neg ? SUM_W'(-r_quo) : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == ST_HOLD) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_pop && r_ovalid) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_job_empty) begin
                        r_state <= ST_DIV;
                        r_step  <= STEP_W'(SUM_W);
                    end
                end
                ST_DIV: begin
                    r_step <= r_step - 1'b1;
                    if (r_step == STEP_W'(1)) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_quo <= (i_job_sum < 0) ? SUM_W'(-i_job_sum) : SUM_W'(i_job_sum);
                r_neg <= (i_job_sum < 0);
                r_div <= i_job_cnt;
                r_rem <= '0;
                r_flg <= i_job_flags;
            end
            ST_DIV: begin
                r_rem <= fits ? CNT_W'(trial - {1'b0, r_div}) : CNT_W'(trial);
                r_quo <= {r_quo[SUM_W-2:0], fits};
            end
            ST_HOLD: begin
                if (out_free) begin
                    r_oval <= res[SAMPLE_BITS-1:0];
                    r_oflg <= r_flg;
                end
            end
            default: begin
                r_rem <= '0;
            end
        endcase
    end

endmodule

>>> hdl/centered_moving_average_frame.sv
// Top level of the centered moving average frame smoother.
// The bit-serial divider takes the next job only once the last result has gone to the output
// register; bins are taken one per cycle while no flush is under way and the job queue has room.
// A frame's last bin stalls input while its min(frame length, HALF_WIDTH) flush jobs issue,
// and longer while the job queue is full.
// Reset (synchronous, active low) empties the queue and output and starts a new frame.
module centered_moving_average_frame import cmaf_pkg::*; #(
    parameter int HALF_WIDTH  = 5,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [SAMPLE_BITS-1:0] i_bin_value,
    input  logic                   i_frame_last,
    output logic                   empty,
    input  logic                   pop,
    output logic [SAMPLE_BITS-1:0] o_smoothed_value,
    output logic                   o_frame_end,
    output logic                   o_run_last
);

    localparam int WIN_LEN = 2 * HALF_WIDTH + 1;
    localparam int CNT_W   = $clog2(WIN_LEN + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WIN_LEN);
    localparam int JOB_W   = SUM_W + CNT_W + FLAGS_W;
    localparam int Q_DEPTH = 4;

    logic                    job_push;
    logic                    job_full;
    logic signed [SUM_W-1:0] job_sum_in;
    logic [CNT_W-1:0]        job_cnt_in;
    t_res_flags              job_flags_in;
    logic [JOB_W-1:0]        job_wdata;
    logic [JOB_W-1:0]        job_rdata;
    logic                    job_pop;
    logic                    job_empty;
    t_res_flags              out_flags;

    assign job_wdata = {job_sum_in, job_cnt_in, job_flags_in};

    cmaf_front #(
        .HALF_WIDTH  (HALF_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_bin_value  (i_bin_value),
        .i_frame_last (i_frame_last),
        .o_job_push   (job_push),
        .i_job_full   (job_full),
        .o_job_sum    (job_sum_in),
        .o_job_cnt    (job_cnt_in),
        .o_job_flags  (job_flags_in)
    );

    cmaf_queue #(
        .WIDTH (JOB_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_wdata),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_rdata),
        .o_empty (job_empty)
    );

    cmaf_back #(
        .HALF_WIDTH  (HALF_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_job_sum   (signed'(job_rdata[JOB_W-1 -: SUM_W])),
        .i_job_cnt   (job_rdata[FLAGS_W +: CNT_W]),
        .i_job_flags (t_res_flags'(job_rdata[FLAGS_W-1:0])),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_value     (o_smoothed_value),
        .o_flags     (out_flags)
    );

    assign o_frame_end = out_flags.frame_end;
    assign o_run_last  = out_flags.run_last;

endmodule

>>> hdl/cmaf_checker.sv
// Port-level checks for the centered moving average frame smoother, bound to the top level.
module cmaf_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   full,
    input logic                   empty,
    input logic                   pop,
    input logic [SAMPLE_BITS-1:0] o_smoothed_value,
    input logic                   o_frame_end,
    input logic                   o_run_last
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input blocked right after reset");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_end) |-> o_run_last)
        else $error("frame end beat not marked as last of its run");

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_smoothed_value)
                              && $stable(o_frame_end) && $stable(o_run_last)))
        else $error("stalled result beat changed");

endmodule

bind centered_moving_average_frame cmaf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_cmaf_checker (.*);

>>> test/tb.sv
// Self-checking testbench for the centered moving average frame smoother.
`timescale 1ns / 100ps

module tb;
    import cmaf_pkg::*;

    localparam int HALF        = 5;
    localparam int SAMPLE_BITS = 16;
    localparam int WIN_LEN     = 2 * HALF + 1;
    localparam int LIMIT       = 200000;
    localparam int HOLD_CYCLES = 800;

    typedef struct {
        logic [SAMPLE_BITS-1:0] value;
        logic                   last;
    } t_bin_beat;

    typedef struct {
        logic [SAMPLE_BITS-1:0] value;
        t_res_flags             flags;
    } t_avg;

    logic                   i_clk;
    logic                   i_rst_n          = 1'b0;
    logic                   push             = 1'b0;
    logic                   full;
    logic [SAMPLE_BITS-1:0] i_bin_value      = '0;
    logic                   i_frame_last     = 1'b0;
    logic                   empty;
    logic                   pop              = 1'b0;
    logic [SAMPLE_BITS-1:0] o_smoothed_value;
    logic                   o_frame_end;
    logic                   o_run_last;

    t_bin_beat pending_bins[$];
    t_avg      avg_due[$];

    logic signed [SAMPLE_BITS-1:0] win [WIN_LEN];
    longint win_sum   = 0;
    int     win_fill  = 0;

    int  n_frames     = 0;
    int  n_bins_in    = 0;
    int  n_results    = 0;
    int  n_bad        = 0;
    int  full_cycles  = 0;
    int  cycles       = 0;
    int  burst_left   = 0;
    int  gap_left     = 0;
    int  pat_cnt      = 0;
    int  pat_mode     = 0;
    logic holding     = 1'b0;

    centered_moving_average_frame #(
        .HALF_WIDTH (HALF),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_bin_value     (i_bin_value),
        .i_frame_last    (i_frame_last),
        .empty           (empty),
        .pop             (pop),
        .o_smoothed_value(o_smoothed_value),
        .o_frame_end     (o_frame_end),
        .o_run_last      (o_run_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void add_bin(logic [SAMPLE_BITS-1:0] value, logic last);
        pending_bins.push_back('{value: value, last: last});
        if (last) n_frames++;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic void queue_avg(longint s, int k, logic fend);
        longint q;
        q = s / k;
        avg_due.push_back('{value: q[SAMPLE_BITS-1:0],
                            flags: '{frame_end: fend, run_last: 1'b0}});
    endfunction

    // Advance the window by one bin and queue every average it releases.
    function automatic void smooth_bin(t_bin_beat b);
        int     n_new;
        int     top;
        int     k;
        longint s;
        n_new = 0;
        if (win_fill < WIN_LEN) win_fill++;
        else win_sum -= win[WIN_LEN-1];
        for (int j = WIN_LEN - 1; j > 0; j--) win[j] = win[j-1];
        win[0] = b.value;
        win_sum += win[0];
        if (win_fill > HALF) begin
            queue_avg(win_sum, win_fill, 1'b0);
            n_new++;
        end
        if (b.last) begin
            top = (win_fill < HALF) ? win_fill : HALF;
            for (int r = top - 1; r >= 0; r--) begin
                k = r + 1 + HALF;
                if (k > win_fill) k = win_fill;
                s = 0;
                for (int j = 0; j < k; j++) s += win[j];
                queue_avg(s, k, r == 0);
                n_new++;
            end
            for (int j = 0; j < WIN_LEN; j++) win[j] = '0;
            win_sum  = 0;
            win_fill = 0;
        end
        if (n_new > 0) avg_due[avg_due.size()-1].flags.run_last = 1'b1;
    endfunction

    // Driver: bursts of offered beats with random gaps between them.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (gap_left > 0) begin
            push     <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_bins.size() == 0) begin
            push <= 1'b0;
        end else begin
            push         <= 1'b1;
            i_bin_value  <= pending_bins[0].value;
            i_frame_last <= pending_bins[0].last;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 16);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // Receiver: pat_cnt periodically redraws the stall pattern at random; hold drops pop entirely.
    always @(negedge i_clk) begin
        pat_cnt <= pat_cnt + 1;
        if (pat_cnt % 64 == 63) pat_mode <= $urandom_range(0, 2);
        if (!i_rst_n || holding) begin
            pop <= 1'b0;
        end else begin
            case (pat_mode)
                0: pop <= 1'b1;
                1: pop <= $urandom_range(0, 1);
                default: pop <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Hold off the receiver long enough for the block to back up and raise full.
    initial begin
        while (n_bins_in < 40) @(negedge i_clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        holding <= 1'b0;
    end

    // Monitor: take accepted bins into the predictor and check popped results.
    always @(posedge i_clk) begin
        t_avg want;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (push && full) full_cycles++;
            if (push && !full) begin
                smooth_bin(pending_bins.pop_front());
                n_bins_in++;
            end
            if (pop && !empty) begin
                n_results++;
                if (avg_due.size() == 0) begin
                    if (n_bad < 10)
                        $display("tb: unexpected result value=%h frame_end=%b run_last=%b",
                                 o_smoothed_value, o_frame_end, o_run_last);
                    n_bad++;
                end else begin
                    want = avg_due.pop_front();
                    if (o_smoothed_value !== want.value ||
                        o_frame_end !== want.flags.frame_end ||
                        o_run_last !== want.flags.run_last) begin
                        if (n_bad < 10)
                            $display("tb: result %0d want %h/%b/%b got %h/%b/%b", n_results,
                                     want.value, want.flags.frame_end, want.flags.run_last,
                                     o_smoothed_value, o_frame_end, o_run_last);
                        n_bad++;
                    end
                end
            end
        end
        if (cycles >= LIMIT) begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        int len;
        int total;

        // single-bin frames at both extremes
        add_bin(16'h7FFF, 1'b1);
        add_bin(16'h8000, 1'b1);
        // short frame, flushed entirely by its last bin
        add_bin(16'h8000, 1'b0);
        add_bin(16'h7FFF, 1'b0);
        add_bin(16'h0001, 1'b0);
        add_bin(16'hFFFF, 1'b1);
        // frame of exactly one more bin than the half width
        for (int i = 0; i < HALF + 1; i++)
            add_bin(16'(i * 4099 - 9000), i == HALF);
        // long frame that saturates the window, extreme sums
        for (int i = 0; i < 13; i++)
            add_bin((i < 7) ? 16'h8000 : 16'h7FFF, i == 12);

        total = 150;
        while (pending_bins.size() < total) begin
            case ($urandom_range(0, 9))
                0, 1, 2:    len = $urandom_range(1, HALF);
                3, 4, 5, 6: len = $urandom_range(HALF + 1, WIN_LEN + 1);
                default:    len = $urandom_range(WIN_LEN + 2, 30);
            endcase
            for (int i = 0; i < len; i++)
                add_bin(rand_sample(), i == len - 1);
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bins.size() != 0) @(posedge i_clk);
        while (avg_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("tb: %0d frames, %0d bins in, %0d averages checked, %0d mismatches",
                 n_frames, n_bins_in, n_results, n_bad);
        $display("tb: input held off by full for %0d cycles, %0d averages left over",
                 full_cycles, avg_due.size());
        if (n_bad == 0 && avg_due.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/cmaf_pkg.sv
hdl/cmaf_queue.sv
hdl/cmaf_front.sv
hdl/cmaf_back.sv
hdl/centered_moving_average_frame.sv
hdl/cmaf_checker.sv
test/tb.sv
